[sv/tbp_pkg.sv]
`timescale 1ns / 1ps

package tbp_pkg;

	localparam int INDEX_BITS    = 11;
	localparam int TABLE_ENTRIES = 1 << INDEX_BITS;
	localparam int HIST_MAX      = 11;
	localparam int HIST_LEN_W    = 4;
	localparam int ADDR_W        = 32;
	localparam int COUNT_W       = 32;
	localparam int IN_DATA_W     = 40;
	localparam int OUT_DATA_W    = 40;

	typedef logic [1:0]            ctr_t;
	typedef logic [INDEX_BITS-1:0] idx_t;
	typedef logic [HIST_MAX-1:0]   hist_t;

	localparam ctr_t CTR_STRONG_TAKEN     = 2'd3;
	localparam ctr_t CTR_STRONG_NOT_TAKEN = 2'd0;
	localparam ctr_t CTR_MAX              = 2'd3;
	localparam ctr_t CTR_MIN              = 2'd0;

	// saturating 2-bit counter step
	function automatic ctr_t train(input ctr_t ctr, input logic taken);
		ctr_t res;
		if (taken) begin
			res = (ctr != CTR_MAX) ? ctr + 2'd1 : CTR_MAX;
		end else begin
			res = (ctr != CTR_MIN) ? ctr - 2'd1 : CTR_MIN;
		end
		return res;
	endfunction

	// history mask, length clamped to 1..HIST_MAX
	function automatic hist_t hist_mask(input logic [HIST_LEN_W-1:0] len);
		logic [HIST_LEN_W-1:0] l;
		logic [HIST_MAX:0]     m;
		l = len;
		if (l < HIST_LEN_W'(1)) begin
			l = HIST_LEN_W'(1);
		end
		if (l > HIST_LEN_W'(HIST_MAX)) begin
			l = HIST_LEN_W'(HIST_MAX);
		end
		m = ((HIST_MAX+1)'(1) << l) - (HIST_MAX+1)'(1);
		return m[HIST_MAX-1:0];
	endfunction

endpackage

[sv/tournament_branch_predictor.sv]
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  resolved branch item
// m_axis    out  m_axis_tvalid / m_axis_tready  prediction result item
// cfg       in   cfg_valid / cfg_ready          history_length write
//
// one item per cycle sustained unless m_axis stalls; tables are read on accept
// and written back as stage 1 moves on, which also loads the output register
// after reset a clearing pass sweeps both tables, one entry per cycle, during
// which s_axis_tready stays low; cfg writes are taken always
// a stalled output holds its item and the item behind it waits in stage 1;
// a write to the entry that the next item just read is forwarded into it

module tournament_branch_predictor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] branch_address, [32] actual_taken, rest zero
	input  logic [tbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] final_prediction, [1] bimodal_prediction, [2] gshare_prediction,
	// [3] prediction_correct, [35:4] correct_total, rest zero
	output logic [tbp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tbp_pkg::HIST_LEN_W-1:0]  cfg_data
);

	localparam int IW = tbp_pkg::INDEX_BITS;

	// bimodal and chooser share the address index: one word {bimodal, chooser}
	logic [3:0]         bc_mem [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t      gs_mem [tbp_pkg::TABLE_ENTRIES];

	// control state
	logic [IW:0]                      clr_cnt_q;
	logic                             clr_done;
	logic [tbp_pkg::HIST_LEN_W-1:0]   hist_len_q;
	tbp_pkg::hist_t                   ghist_q;
	logic [tbp_pkg::COUNT_W-1:0]      cnt_q;
	logic                             valid_s1;
	logic                             out_valid_q;
	logic                             fwd_valid_q;

	// payload
	tbp_pkg::idx_t                    pc_s1;
	tbp_pkg::idx_t                    gi_s1;
	logic                             taken_s1;
	logic [3:0]                       bc_rd_s1;
	tbp_pkg::ctr_t                    gs_rd_s1;
	tbp_pkg::idx_t                    fwd_bc_addr_q;
	tbp_pkg::idx_t                    fwd_gs_addr_q;
	logic [3:0]                       fwd_bc_q;
	tbp_pkg::ctr_t                    fwd_gs_q;
	logic [tbp_pkg::OUT_DATA_W-1:0]   out_data_q;

	// input side
	logic                             in_acc;
	logic                             s1_go;
	tbp_pkg::hist_t                   hm;
	tbp_pkg::hist_t                   hist;
	tbp_pkg::idx_t                    pc_in;
	tbp_pkg::idx_t                    gi_in;
	logic                             taken_in;

	// stage 1 logic
	logic [3:0]                       bc_word;
	tbp_pkg::ctr_t                    gs_word;
	tbp_pkg::ctr_t                    bim;
	tbp_pkg::ctr_t                    cho;
	logic                             bp;
	logic                             gp;
	logic                             fp;
	logic                             bim_ok;
	logic                             gs_ok;
	logic                             ok;
	tbp_pkg::ctr_t                    bim_new;
	tbp_pkg::ctr_t                    cho_new;
	tbp_pkg::ctr_t                    gs_new;
	logic [tbp_pkg::COUNT_W-1:0]      cnt_next;

	// memory write port
	logic                             mem_we;
	tbp_pkg::idx_t                    bc_waddr;
	tbp_pkg::idx_t                    gs_waddr;
	logic [3:0]                       bc_wdata;
	tbp_pkg::ctr_t                    gs_wdata;

	assign clr_done  = clr_cnt_q[IW];
	assign cfg_ready = 1'b1;

	// stage 1 moves on when the output register is free or being drained
	assign s1_go         = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = clr_done && (!valid_s1 || s1_go);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// index formation at accept; history is live in the register
	assign hm       = tbp_pkg::hist_mask(hist_len_q);
	assign hist     = ghist_q & hm;
	assign pc_in    = s_axis_tdata[IW-1:0];
	assign gi_in    = pc_in ^ IW'(hist);
	assign taken_in = s_axis_tdata[tbp_pkg::ADDR_W];

	// forward the last write-back over the stale read of the same entry
	always_comb begin
		bc_word = bc_rd_s1;
		gs_word = gs_rd_s1;
		if (fwd_valid_q && (fwd_bc_addr_q == pc_s1)) begin
			bc_word = fwd_bc_q;
		end
		if (fwd_valid_q && (fwd_gs_addr_q == gi_s1)) begin
			gs_word = fwd_gs_q;
		end
	end

	assign bim    = bc_word[3:2];
	assign cho    = bc_word[1:0];
	assign bp     = bim[1];
	assign gp     = gs_word[1];
	assign fp     = cho[1] ? bp : gp;
	assign bim_ok = (bp == taken_s1);
	assign gs_ok  = (gp == taken_s1);
	assign ok     = (fp == taken_s1);

	// chooser only moves when exactly one component was right
	assign bim_new  = tbp_pkg::train(bim, taken_s1);
	assign gs_new   = tbp_pkg::train(gs_word, taken_s1);
	assign cho_new  = (bim_ok != gs_ok) ? tbp_pkg::train(cho, bim_ok) : cho;
	assign cnt_next = (ok && (cnt_q != '1)) ? cnt_q + tbp_pkg::COUNT_W'(1) : cnt_q;

	// clearing pass has the write port until done
	always_comb begin
		if (!clr_done) begin
			mem_we   = 1'b1;
			bc_waddr = clr_cnt_q[IW-1:0];
			gs_waddr = clr_cnt_q[IW-1:0];
			bc_wdata = {tbp_pkg::CTR_STRONG_TAKEN, tbp_pkg::CTR_STRONG_NOT_TAKEN};
			gs_wdata = tbp_pkg::CTR_STRONG_TAKEN;
		end else begin
			mem_we   = s1_go;
			bc_waddr = pc_s1;
			gs_waddr = gi_s1;
			bc_wdata = {bim_new, cho_new};
			gs_wdata = gs_new;
		end
	end

	// tables: one write, one registered read each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bc_mem[bc_waddr] <= bc_wdata;
			gs_mem[gs_waddr] <= gs_wdata;
		end
		if (in_acc) begin
			bc_rd_s1 <= bc_mem[pc_in];
			gs_rd_s1 <= gs_mem[gi_in];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pc_s1    <= pc_in;
			gi_s1    <= gi_in;
			taken_s1 <= taken_in;
		end
		if (s1_go) begin
			fwd_bc_addr_q <= pc_s1;
			fwd_gs_addr_q <= gi_s1;
			fwd_bc_q      <= {bim_new, cho_new};
			fwd_gs_q      <= gs_new;
			out_data_q    <= {4'd0, cnt_next, ok, gp, bp, fp};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			hist_len_q  <= tbp_pkg::HIST_LEN_W'(tbp_pkg::HIST_MAX);
			ghist_q     <= '0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (!clr_done) begin
				clr_cnt_q <= clr_cnt_q + (IW+1)'(1);
			end
			if (cfg_valid && cfg_ready) begin
				hist_len_q <= cfg_data;
			end
			if (in_acc) begin
				ghist_q <= ({hist[tbp_pkg::HIST_MAX-2:0], taken_in}) & hm;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
				fwd_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// no item taken while the tables are being cleared
	a_no_acc_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> clr_done)
		else $error("item accepted during clearing pass");

	// stage 1 never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !s1_go)
		else $error("result overwritten while stalled");

	// forwarding register only holds write-backs made after the clear
	a_fwd_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid_q |-> clr_done)
		else $error("forward valid before clear done");

	// correct count never goes down
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		clr_done |=> (cnt_q >= $past(cnt_q)))
		else $error("correct count decreased");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

	// one expected result item, with the fields that the output port carries
	typedef struct packed {
		logic                        final_p;
		logic                        bim_p;
		logic                        gsh_p;
		logic                        hit;
		logic [tbp_pkg::COUNT_W-1:0] total;
	} prediction_t;

	// one resolved branch waiting to be offered
	typedef struct {
		logic [tbp_pkg::ADDR_W-1:0] addr;
		logic                       taken;
	} branch_t;

	// outcome behavior of one hot branch in the random workload
	typedef enum {
		PAT_ALWAYS,
		PAT_NEVER,
		PAT_LOOP,
		PAT_ALTERNATE,
		PAT_ECHO,
		PAT_RANDOM
	} pattern_e;

	localparam int HOLD_CYCLES = 300;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 210;
	localparam int HOT_BRANCHES = 8;

	// tournament predictor mirror: tables, history, hit count and expected results
	class branch_scoreboard;
		tbp_pkg::ctr_t                  bim_tbl[tbp_pkg::TABLE_ENTRIES];
		tbp_pkg::ctr_t                  gsh_tbl[tbp_pkg::TABLE_ENTRIES];
		tbp_pkg::ctr_t                  sel_tbl[tbp_pkg::TABLE_ENTRIES];
		tbp_pkg::hist_t                 ghist;
		logic [tbp_pkg::COUNT_W-1:0]    hits;
		logic [tbp_pkg::HIST_LEN_W-1:0] hlen;
		prediction_t                    expected_q[$];
		int                             errors;

		function new();
			foreach (bim_tbl[i]) begin
				bim_tbl[i] = tbp_pkg::CTR_STRONG_TAKEN;
				gsh_tbl[i] = tbp_pkg::CTR_STRONG_TAKEN;
				sel_tbl[i] = tbp_pkg::CTR_STRONG_NOT_TAKEN;
			end
			ghist  = '0;
			hits   = '0;
			hlen   = tbp_pkg::HIST_LEN_W'(tbp_pkg::HIST_MAX);
			errors = 0;
		endfunction

		function void set_history_length(logic [tbp_pkg::HIST_LEN_W-1:0] len);
			hlen = len;
		endfunction

		function tbp_pkg::ctr_t step_counter(tbp_pkg::ctr_t c, logic up);
			if (up) begin
				return (c == 2'd3) ? c : c + 2'd1;
			end
			return (c == 2'd0) ? c : c - 2'd1;
		endfunction

		// predict, then train all three tables on the outcome
		function void note_branch(logic [tbp_pkg::ADDR_W-1:0] addr, logic taken);
			int             len;
			tbp_pkg::hist_t mask;
			tbp_pkg::hist_t hist;
			tbp_pkg::idx_t  pc;
			tbp_pkg::idx_t  gi;
			logic           bim_ok;
			logic           gsh_ok;
			prediction_t    p;
			len = hlen;
			if (len < 1) begin
				len = 1;
			end
			if (len > tbp_pkg::HIST_MAX) begin
				len = tbp_pkg::HIST_MAX;
			end
			mask = tbp_pkg::hist_t'((1 << len) - 1);
			hist = ghist & mask;
			pc = addr[tbp_pkg::INDEX_BITS-1:0];
			gi = pc ^ tbp_pkg::idx_t'(hist);
			// upper counter bit set means 2 or 3, i.e. taken / prefer bimodal
			p.bim_p   = bim_tbl[pc][1];
			p.gsh_p   = gsh_tbl[gi][1];
			p.final_p = sel_tbl[pc][1] ? p.bim_p : p.gsh_p;
			p.hit     = (p.final_p == taken);
			bim_ok = (p.bim_p == taken);
			gsh_ok = (p.gsh_p == taken);
			bim_tbl[pc] = step_counter(bim_tbl[pc], taken);
			gsh_tbl[gi] = step_counter(gsh_tbl[gi], taken);
			// selector only moves when exactly one component was right
			if (bim_ok != gsh_ok) begin
				sel_tbl[pc] = step_counter(sel_tbl[pc], bim_ok);
			end
			ghist = ((hist << 1) | tbp_pkg::hist_t'(taken)) & mask;
			if (p.hit && hits != '1) begin
				hits++;
			end
			p.total = hits;
			expected_q = {expected_q, p};
		endfunction

		function void match(string field, logic [tbp_pkg::COUNT_W-1:0] want,
				logic [tbp_pkg::COUNT_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [tbp_pkg::OUT_DATA_W-1:0] d);
			prediction_t p;
			if (expected_q.size() == 0) begin
				$error("result item with nothing expected: %h", d);
				errors++;
				return;
			end
			p = expected_q.pop_front();
			match("final_prediction", p.final_p, d[0]);
			match("bimodal_prediction", p.bim_p, d[1]);
			match("gshare_prediction", p.gsh_p, d[2]);
			match("prediction_correct", p.hit, d[3]);
			match("correct_total", p.total, d[4 +: tbp_pkg::COUNT_W]);
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	// [31:0] branch_address, [32] actual_taken, rest zero
	logic [tbp_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	// [0] final, [1] bimodal, [2] gshare, [3] correct, [35:4] correct_total
	logic [tbp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [tbp_pkg::HIST_LEN_W-1:0] cfg_data;

	branch_scoreboard      sb = new();
	branch_t               pending_branches[$];

	// idle switches for both sides, and the long hold-off request
	bit                    sender_idle_on = 1'b1;
	bit                    rcv_idle_on = 1'b1;
	int                    hold_req = 0;
	int                    hold_seen = 0;
	int unsigned           hold_left = 0;

	// history lengths per phase: both clamp cases, both bounds, mid values
	logic [tbp_pkg::HIST_LEN_W-1:0] phase_len[NUM_PHASES] = '{4'd0, 4'd15, 4'd1,
		4'd11, 4'd5, 4'd12, 4'd6, 4'd2};

	tournament_branch_predictor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// result side: check each accepted item, then pick next cycle's tready
	// a new hold request blanks tready until hold_left runs down, so the pipe backs up
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
		end
		if (hold_req != hold_seen) begin
			hold_seen     <= hold_req;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(rcv_idle_on && $urandom_range(99) < 18);
		end
	end

	task automatic push_branch(logic [tbp_pkg::ADDR_W-1:0] addr, logic taken);
		branch_t b;
		b.addr  = addr;
		b.taken = taken;
		pending_branches = {pending_branches, b};
	endtask

	// hot branches with loop / bias / correlation behavior, plus some noise
	task automatic queue_workload(int n);
		logic [tbp_pkg::ADDR_W-1:0] hot_addr[HOT_BRANCHES];
		pattern_e                   pat[HOT_BRANCHES];
		int                         period[HOT_BRANCHES];
		int                         trip[HOT_BRANCHES];
		logic                       last_taken;
		logic                       taken;
		int                         j;
		last_taken = 1'b0;
		for (int i = 0; i < HOT_BRANCHES; i++) begin
			hot_addr[i] = $urandom;
			// some hot branches alias the index of their neighbor
			if (i > 0 && i % 3 == 0) begin
				hot_addr[i] = {hot_addr[i][tbp_pkg::ADDR_W-1:tbp_pkg::INDEX_BITS],
					hot_addr[i-1][tbp_pkg::INDEX_BITS-1:0]};
			end
			pat[i]    = pattern_e'($urandom_range(0, 5));
			period[i] = $urandom_range(2, 9);
			trip[i]   = 0;
		end
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 15) begin
				taken = 1'($urandom_range(1));
				push_branch($urandom, taken);
			end else begin
				j = $urandom_range(HOT_BRANCHES - 1);
				trip[j]++;
				case (pat[j])
					PAT_ALWAYS:    taken = 1'b1;
					PAT_NEVER:     taken = 1'b0;
					PAT_LOOP:      taken = (trip[j] % period[j]) != 0;
					PAT_ALTERNATE: taken = trip[j][0];
					PAT_ECHO:      taken = last_taken;
					default:       taken = 1'($urandom_range(1));
				endcase
				push_branch(hot_addr[j], taken);
			end
			last_taken = taken;
		end
	endtask

	// offer queued branches; at most one tvalid update per edge
	task automatic drive_branches();
		bit      offering;
		branch_t cur;
		offering = 1'b0;
		while (pending_branches.size() > 0 || offering) begin
			@(posedge clk);
			if (offering && s_axis_tready) begin
				sb.note_branch(cur.addr, cur.taken);
				offering = 1'b0;
			end
			if (!offering) begin
				if (pending_branches.size() > 0 &&
						!(sender_idle_on && $urandom_range(99) < 18)) begin
					cur = pending_branches.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {{(tbp_pkg::IN_DATA_W-tbp_pkg::ADDR_W-1){1'b0}},
						cur.taken, cur.addr};
					offering = 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	endtask

	task automatic write_history_length(logic [tbp_pkg::HIST_LEN_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		sb.set_history_length(len);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.outstanding() > 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed items at the reset history length; the clearing pass holds
		// tready low first, the driver simply waits it out
		push_branch(32'h0000_0000, 1'b1);
		// all-ones address trained down: bimodal turns right, fresh gshare is wrong
		repeat (3) push_branch(32'hFFFF_FFFF, 1'b0);
		// upper address bits alias onto entry 0
		push_branch(32'h0000_0800, 1'b1);
		push_branch(32'h0000_07FF, 1'b1);
		repeat (2) push_branch(32'hFFFF_F800, 1'b0);
		for (int i = 0; i < 6; i++) begin
			push_branch(32'h1234_5678, i[0]);
		end
		repeat (3) push_branch(32'hA5A5_A5A5, 1'b0);
		push_branch(32'h5A5A_5A5A, 1'b1);
		drive_branches();
		wait_drained();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// phase 2 runs with no idling at all; phase 4 backs the pipe up
			sender_idle_on = !(ph == 2 || ph == 4);
			rcv_idle_on    <= (ph != 2);
			write_history_length(phase_len[ph]);
			queue_workload(PHASE_ITEMS);
			if (ph == 4) begin
				hold_req <= hold_req + 1;
			end
			drive_branches();
			// sender pauses here until every result is back
			wait_drained();
		end

		// catch any stray result items
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
sv/tbp_pkg.sv
sv/tournament_branch_predictor.sv
dv/tb.sv
